FILE: design/four_level_page_table_walker_assert.svh
// assertion helpers for the page-table walker checker
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH

// same-cycle implication, off during reset
`define PTW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page-table walker check failed");

// next-cycle implication, off during reset
`define PTW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page-table walker check failed");

// next-cycle implication that also holds across reset
`define PTW_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("page-table walker reset check failed");

`endif

FILE: design/ptw_pkg.sv
`timescale 1ns / 1ps
package ptw_pkg;

  localparam int TABLE_WORDS = 65536;
  localparam int TBL_AW = $clog2(TABLE_WORDS);
  localparam logic [TBL_AW-1:0] TBL_LAST = TBL_AW'(TABLE_WORDS - 1);
  // highest 4 KiB table page whose 512 words still fit in the store
  localparam logic [39:0] TBL_MAX_PAGE = 40'((TABLE_WORDS - 512) / 512);

  localparam int PTE_PRESENT = 0;
  localparam int PTE_LARGE = 7;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TRANSLATE = 1'b1;

  localparam logic REG_ROOT = 1'b0;
  localparam logic REG_ENABLE = 1'b1;

  typedef enum logic [2:0] {
    ST_WRITTEN  = 3'd0,
    ST_OK       = 3'd1,
    ST_DISABLED = 3'd2,
    ST_NONCANON = 3'd3,
    ST_ABSENT   = 3'd4,
    ST_OUTSIDE  = 3'd5
  } ptw_status_t;

  typedef enum logic [1:0] {
    PS_4K = 2'd0,
    PS_2M = 2'd1,
    PS_1G = 2'd2
  } ptw_size_t;

  typedef enum logic [1:0] {
    K_WRITE = 2'd0,
    K_WALK  = 2'd1,
    K_FAULT = 2'd2
  } ptw_kind_t;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_WALK  = 2'd2
  } ptw_bk_state_t;

  typedef struct packed {
    ptw_kind_t   kind;
    ptw_status_t status;
    logic [47:0] va;
    logic [15:0] word_index;
    logic [63:0] word_value;
  } ptw_cmd_t;

  typedef struct packed {
    ptw_status_t status;
    logic [51:0] pa;
    ptw_size_t   size;
  } ptw_res_t;

  typedef struct packed {
    logic cmd_pop;
    logic clearing;
  } ptw_bk_stat_t;

  function automatic logic [TBL_AW-1:0] tbl_index(input logic [39:0] page,
                                                  input logic [8:0] idx);
    logic [48:0] word;
    word = {page, idx};
    return word[TBL_AW-1:0];
  endfunction

  function automatic logic page_outside(input logic [39:0] page);
    return page > TBL_MAX_PAGE;
  endfunction

endpackage

FILE: design/ptw_front.sv
`timescale 1ns / 1ps
module ptw_front import ptw_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  logic         command,
  input  logic [63:0]  virt_addr,
  input  logic [15:0]  word_index,
  input  logic [63:0]  word_value,
  input  logic         walker_enable,
  input  ptw_bk_stat_t bk_stat,
  output logic         cmd_valid,
  output ptw_cmd_t     cmd
);

  ptw_cmd_t   q_data [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push_ok;
  logic       pop_ok;
  logic       canonical;
  ptw_cmd_t   new_cmd;

  assign full = bk_stat.clearing || (count == 2'd2);
  assign push_ok = push && !full;
  assign pop_ok = bk_stat.cmd_pop && cmd_valid;
  assign cmd_valid = (count != 2'd0);
  assign cmd = q_data[rd_ptr];

  // bits 63..47 all equal
  assign canonical = (virt_addr[63:47] == '0) || (virt_addr[63:47] == '1);

  always_comb begin
    new_cmd.kind = K_WALK;
    new_cmd.status = ST_OK;
    new_cmd.va = virt_addr[47:0];
    new_cmd.word_index = word_index;
    new_cmd.word_value = word_value;
    if (command == CMD_WRITE) begin
      new_cmd.kind = K_WRITE;
      new_cmd.status = ST_WRITTEN;
    end else if (!walker_enable) begin
      new_cmd.kind = K_FAULT;
      new_cmd.status = ST_DISABLED;
    end else if (!canonical) begin
      new_cmd.kind = K_FAULT;
      new_cmd.status = ST_NONCANON;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_data[wr_ptr] <= new_cmd;
    end
  end

endmodule

FILE: design/ptw_back.sv
`timescale 1ns / 1ps
module ptw_back import ptw_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cmd_valid,
  input  ptw_cmd_t     cmd,
  input  logic [51:0]  root_table_address,
  input  logic         res_space,
  output ptw_bk_stat_t bk_stat,
  output logic         res_push,
  output ptw_res_t     res
);

  logic [63:0]       store [TABLE_WORDS];
  logic [63:0]       mem_rdata;
  logic              mem_we;
  logic [TBL_AW-1:0] mem_addr;
  logic [63:0]       mem_wdata;

  ptw_bk_state_t     state;
  ptw_bk_state_t     state_next;
  logic [TBL_AW-1:0] clr_cnt;
  logic [1:0]        level;
  logic [47:0]       va;
  logic              cmd_pop;
  logic              walk_load;
  logic              walk_step;
  logic              root_outside;
  logic              wr_in_range;
  logic [8:0]        next_idx;
  logic [63:0]       entry;

  assign bk_stat.cmd_pop = cmd_pop;
  assign bk_stat.clearing = (state == BK_CLEAR);
  assign root_outside = page_outside(root_table_address[51:12]);
  assign wr_in_range = (32'(cmd.word_index) < 32'(TABLE_WORDS));
  assign entry = mem_rdata;

  // index into the table one level down from the entry now read
  always_comb begin
    case (level)
      2'd0:    next_idx = va[38:30];
      2'd1:    next_idx = va[29:21];
      default: next_idx = va[20:12];
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: begin
        if (clr_cnt == TBL_LAST) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (walk_load) begin
          state_next = BK_WALK;
        end
      end
      BK_WALK: begin
        if (res_push) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    mem_we = 1'b0;
    mem_addr = '0;
    mem_wdata = '0;
    res_push = 1'b0;
    res.status = ST_WRITTEN;
    res.pa = '0;
    res.size = PS_4K;
    walk_load = 1'b0;
    walk_step = 1'b0;
    unique case (state)
      BK_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr_cnt;
      end
      BK_IDLE: begin
        // only take an item when its result has room downstream
        if (cmd_valid && res_space) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            K_WRITE: begin
              mem_we = wr_in_range;
              mem_addr = TBL_AW'(cmd.word_index);
              mem_wdata = cmd.word_value;
              res_push = 1'b1;
              res.status = ST_WRITTEN;
            end
            K_WALK: begin
              if (root_outside) begin
                res_push = 1'b1;
                res.status = ST_OUTSIDE;
              end else begin
                walk_load = 1'b1;
                mem_addr = tbl_index(root_table_address[51:12], cmd.va[47:39]);
              end
            end
            default: begin
              res_push = 1'b1;
              res.status = cmd.status;
            end
          endcase
        end
      end
      BK_WALK: begin
        if (!entry[PTE_PRESENT]) begin
          res_push = 1'b1;
          res.status = ST_ABSENT;
        end else if (level == 2'd1 && entry[PTE_LARGE]) begin
          res_push = 1'b1;
          res.status = ST_OK;
          res.pa = {entry[51:30], va[29:0]};
          res.size = PS_1G;
        end else if (level == 2'd2 && entry[PTE_LARGE]) begin
          res_push = 1'b1;
          res.status = ST_OK;
          res.pa = {entry[51:21], va[20:0]};
          res.size = PS_2M;
        end else if (level == 2'd3) begin
          res_push = 1'b1;
          res.status = ST_OK;
          res.pa = {entry[51:12], va[11:0]};
          res.size = PS_4K;
        end else if (page_outside(entry[51:12])) begin
          res_push = 1'b1;
          res.status = ST_OUTSIDE;
        end else begin
          walk_step = 1'b1;
          mem_addr = tbl_index(entry[51:12], next_idx);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
      clr_cnt <= '0;
      level <= 2'd0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_cnt <= clr_cnt + TBL_AW'(1);
      end
      if (walk_load) begin
        level <= 2'd0;
      end else if (walk_step) begin
        level <= level + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (walk_load) begin
      va <= cmd.va;
    end
  end

  // single-port table store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= mem_wdata;
    end else begin
      mem_rdata <= store[mem_addr];
    end
  end

endmodule

FILE: design/ptw_resq.sv
`timescale 1ns / 1ps
module ptw_resq import ptw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        res_push,
  input  ptw_res_t    res,
  output logic        res_space,
  input  logic        pop,
  output logic        empty,
  output logic [2:0]  status,
  output logic [51:0] phys_addr,
  output logic [1:0]  page_size
);

  ptw_res_t   q_data [2];
  ptw_res_t   head;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop_ok;

  assign empty = (count == 2'd0);
  assign res_space = (count != 2'd2);
  assign pop_ok = pop && !empty;
  assign head = q_data[rd_ptr];
  assign status = head.status;
  assign phys_addr = head.pa;
  assign page_size = head.size;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (res_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, res_push} - {1'b0, pop_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      q_data[wr_ptr] <= res;
    end
  end

endmodule

FILE: design/four_level_page_table_walker.sv
// Four-level page-table walker with its own 65536 x 64-bit table store. Items go in through
// push/full and results come out through empty/pop, one result per item, in order. After
// reset the store is cleared one word per cycle, with full held high; the registers can be
// written meanwhile. Registers sit on the 64-bit APB port: root table address at 0x0,
// walker enable (bit 0) at 0x8; write them only while the walker is idle. A table-word
// write is done in the back end as it is taken. A translation first issues the top-level
// read and then reads one entry per level it examines, since each entry read from the
// single-port store gives the address of the next; the back end takes no new item until
// the walk is done. Disabled and non-canonical requests, and a root table outside the
// store, finish without reading the store. A two-entry command queue and a two-entry
// result queue sit at either side, each registering what is pushed into it.
`timescale 1ns / 1ps
module four_level_page_table_walker import ptw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        command,
  input  logic [63:0] virt_addr,
  input  logic [15:0] word_index,
  input  logic [63:0] word_value,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic [51:0] phys_addr,
  output logic [1:0]  page_size,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [51:0]  root_table_address;
  logic         walker_enable;
  logic         cfg_wr;
  ptw_bk_stat_t bk_stat;
  logic         cmd_valid;
  ptw_cmd_t     cmd;
  logic         res_push;
  ptw_res_t     res;
  logic         res_space;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_address <= '0;
      walker_enable <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        REG_ROOT:   root_table_address <= pwdata[51:0];
        REG_ENABLE: walker_enable <= pwdata[0];
        default:    walker_enable <= walker_enable;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_ROOT:   prdata = {12'd0, root_table_address};
      REG_ENABLE: prdata = {63'd0, walker_enable};
      default:    prdata = '0;
    endcase
  end

  ptw_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .command       (command),
    .virt_addr     (virt_addr),
    .word_index    (word_index),
    .word_value    (word_value),
    .walker_enable (walker_enable),
    .bk_stat       (bk_stat),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd)
  );

  ptw_back u_back (
    .clk                (clk),
    .rst                (rst),
    .cmd_valid          (cmd_valid),
    .cmd                (cmd),
    .root_table_address (root_table_address),
    .res_space          (res_space),
    .bk_stat            (bk_stat),
    .res_push           (res_push),
    .res                (res)
  );

  ptw_resq u_resq (
    .clk       (clk),
    .rst       (rst),
    .res_push  (res_push),
    .res       (res),
    .res_space (res_space),
    .pop       (pop),
    .empty     (empty),
    .status    (status),
    .phys_addr (phys_addr),
    .page_size (page_size)
  );

endmodule

FILE: design/ptw_checker.sv
`timescale 1ns / 1ps
`include "four_level_page_table_walker_assert.svh"
module ptw_checker import ptw_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic [2:0]  status,
  input logic [51:0] phys_addr,
  input logic [1:0]  page_size
);

  logic [3:0] outst;
  logic       in_xfer;
  logic       out_xfer;
  logic       fields_zero;

  assign in_xfer = push && !full;
  assign out_xfer = pop && !empty;
  assign fields_zero = (phys_addr == '0) && (page_size == '0);

  // items taken in but whose result has not been transferred out
  always_ff @(posedge clk) begin
    if (rst) begin
      outst <= 4'd0;
    end else begin
      outst <= outst + 4'(in_xfer) - 4'(out_xfer);
    end
  end

  `PTW_ASSERT_RST(a_reset_quiet, rst, full && empty)
  `PTW_ASSERT_IMP(a_no_invented_result, !empty, outst != 4'd0)
  `PTW_ASSERT_IMP(a_full_when_backed_up, outst >= 4'd4, full)
  `PTW_ASSERT_NXT(a_fault_fields_zero, 1'b1, empty || status == ST_OK || fields_zero)

endmodule

bind four_level_page_table_walker ptw_checker u_checker (.*);
